// ===== sv/pcfd_pkg.sv =====
package pcfd_pkg;

    localparam int CNT_W      = 32;
    localparam int CLS_W      = 4;
    localparam int TICK_W     = 6;
    localparam int S_DATA_W   = 32;
    localparam int S_USER_W   = 1;
    localparam int M_DATA_W   = 232;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int NUM_LT     = 6;
    localparam int NUM_WN     = 4;

    localparam logic [15:0] ETH_TYPE_IP  = 16'h0800;
    localparam logic [15:0] ETH_TYPE_ARP = 16'h0806;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_IGMP = 8'd2;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    localparam int FLAG_SYN_BIT = 1;
    localparam int FLAG_ACK_BIT = 4;

    localparam logic OP_PACKET = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic [CLS_W-1:0] CLS_NONE  = 4'd0;
    localparam logic [CLS_W-1:0] CLS_ARP   = 4'd1;
    localparam logic [CLS_W-1:0] CLS_TCP   = 4'd2;
    localparam logic [CLS_W-1:0] CLS_SYN   = 4'd3;
    localparam logic [CLS_W-1:0] CLS_ACK   = 4'd4;
    localparam logic [CLS_W-1:0] CLS_UDP   = 4'd5;
    localparam logic [CLS_W-1:0] CLS_ICMP  = 4'd6;
    localparam logic [CLS_W-1:0] CLS_IGMP  = 4'd7;
    localparam logic [CLS_W-1:0] CLS_OTHER = 4'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_SYN_THR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_THR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UDP_THR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ICMP_THR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd4;

    // Lifetime counter slots.
    localparam int LT_TOTAL = 0;
    localparam int LT_SYN   = 1;
    localparam int LT_ACK   = 2;
    localparam int LT_UDP   = 3;
    localparam int LT_ICMP  = 4;
    localparam int LT_OTHER = 5;

    // Window counter slots, also the alarm bit order.
    localparam int WN_SYN  = 0;
    localparam int WN_ACK  = 1;
    localparam int WN_UDP  = 2;
    localparam int WN_ICMP = 3;

    localparam logic [CNT_W-1:0]  THR_RESET = 32'd1000;
    localparam logic [TICK_W-1:0] LAST_TICK = 6'd59;

    typedef struct packed {
        logic [CLS_W-1:0] cls;
        logic             counted;
        logic             syn;
        logic             ack;
        logic             udp;
        logic             icmp;
        logic             other;
    } pcfd_hit_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c, input logic en);
        return (en && (c != {CNT_W{1'b1}})) ? c + 1'b1 : c;
    endfunction

endpackage

// ===== sv/pcfd_classify.sv =====
module pcfd_classify (
    input  logic                 operation,
    input  logic [15:0]          ether_type,
    input  logic [7:0]           ip_protocol,
    input  logic [7:0]           tcp_flags,
    output pcfd_pkg::pcfd_hit_t  hit
);
    import pcfd_pkg::*;

    always_comb begin
        hit = '0;
        hit.cls = CLS_NONE;
        if (operation == OP_PACKET) begin
            if (ether_type == ETH_TYPE_ARP) begin
                hit.cls     = CLS_ARP;
                hit.counted = 1'b1;
            end else if (ether_type == ETH_TYPE_IP) begin
                hit.counted = 1'b1;
                if (ip_protocol == PROTO_TCP) begin
                    hit.syn = tcp_flags[FLAG_SYN_BIT];
                    hit.ack = tcp_flags[FLAG_ACK_BIT];
                    // ACK takes the label when both flags are set.
                    if (hit.ack) begin
                        hit.cls = CLS_ACK;
                    end else if (hit.syn) begin
                        hit.cls = CLS_SYN;
                    end else begin
                        hit.cls = CLS_TCP;
                    end
                end else if (ip_protocol == PROTO_UDP) begin
                    hit.cls = CLS_UDP;
                    hit.udp = 1'b1;
                end else if (ip_protocol == PROTO_ICMP) begin
                    hit.cls  = CLS_ICMP;
                    hit.icmp = 1'b1;
                end else if (ip_protocol == PROTO_IGMP) begin
                    hit.cls   = CLS_IGMP;
                    hit.other = 1'b1;
                end else begin
                    hit.cls   = CLS_OTHER;
                    hit.other = 1'b1;
                end
            end
        end
    end

endmodule

// ===== sv/packet_class_flood_detector_core.sv =====
// Packet class flood detector.
// The s_ channel carries one request per packet header summary or per one-second
// tick; s_tuser selects which. Each packet is classified (ARP, TCP, SYN, ACK, UDP,
// ICMP, IGMP, other) and its lifetime totals and window counters advance,
// saturating at all ones. A tick smooths the packet rate and, at the end of a
// window of one tick or sixty ticks, compares the SYN, ACK, UDP and ICMP window
// counts against their thresholds and raises the alarms.
// Every request yields exactly one result on the m_ channel.
// The cfg_ channel writes the thresholds and the window mode; it is always ready
// and must only be used while no request is in flight.
// A request accepted at the input sits in the input register, and its
// classification and counter update move into the result register once that
// register can load, and the result is then offered on the m_ channel.
// Throughput is one request per cycle while m_tready does not stall the result.
// When m_tready is low the result register holds, the input register can still
// fill once, and s_tready then drops until the result is taken.
// A synchronous reset clears all counters, the rate, and the tick position, and
// reloads thresholds to 1000 and the mode to per-tick.
module packet_class_flood_detector_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // ether_type[15:0], ip_protocol[23:16], tcp_flags[31:24]
    input  logic [pcfd_pkg::S_DATA_W-1:0]      s_tdata,
    // operation[0]
    input  logic [pcfd_pkg::S_USER_W-1:0]      s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // packet_class[3:0], total_packets[35:4], syn_total[67:36], ack_total[99:68],
    // udp_total[131:100], icmp_total[163:132], other_total[195:164],
    // packet_rate[227:196], syn_alarm[228], ack_alarm[229], udp_alarm[230],
    // icmp_alarm[231]
    output logic [pcfd_pkg::M_DATA_W-1:0]      m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pcfd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pcfd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import pcfd_pkg::*;

    // Input register stage.
    logic             in_valid_reg;
    logic             in_op_reg;
    logic [15:0]      in_etype_reg;
    logic [7:0]       in_proto_reg;
    logic [7:0]       in_flags_reg;

    // Result register stage.
    logic                 out_valid_reg;
    logic [M_DATA_W-1:0]  out_data_reg;
    logic [M_DATA_W-1:0]  out_data_next;

    // Configuration.
    logic [CNT_W-1:0]  thr_reg [NUM_WN];
    logic              mode_reg;

    // Counting state.
    logic [CNT_W-1:0]  lt_reg   [NUM_LT];
    logic [CNT_W-1:0]  lt_next  [NUM_LT];
    logic [CNT_W-1:0]  win_reg  [NUM_WN];
    logic [CNT_W-1:0]  win_next [NUM_WN];
    logic [CNT_W-1:0]  spc_reg;
    logic [CNT_W-1:0]  spc_next;
    logic [CNT_W-1:0]  rate_reg;
    logic [CNT_W-1:0]  rate_next;
    logic [TICK_W-1:0] tick_reg;
    logic [TICK_W-1:0] tick_next;

    pcfd_hit_t         hit;
    logic              is_tick;
    logic              window_end;
    logic              clear_window;
    logic [CNT_W:0]    rate_sum;
    logic [NUM_WN-1:0] alarm;
    logic              out_load;
    logic              advance;

    // The result register may load when it is empty or being drained this cycle.
    assign out_load  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_load;
    assign s_tready  = !in_valid_reg || out_load;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    pcfd_classify u_classify (
        .operation   (in_op_reg),
        .ether_type  (in_etype_reg),
        .ip_protocol (in_proto_reg),
        .tcp_flags   (in_flags_reg),
        .hit         (hit)
    );

    always_comb begin
        is_tick      = (in_op_reg == OP_TICK);
        window_end   = (mode_reg == 1'b0) || (tick_reg >= LAST_TICK);
        clear_window = is_tick && window_end;

        lt_next[LT_TOTAL] = sat_inc(lt_reg[LT_TOTAL], hit.counted);
        lt_next[LT_SYN]   = sat_inc(lt_reg[LT_SYN],   hit.syn);
        lt_next[LT_ACK]   = sat_inc(lt_reg[LT_ACK],   hit.ack);
        lt_next[LT_UDP]   = sat_inc(lt_reg[LT_UDP],   hit.udp);
        lt_next[LT_ICMP]  = sat_inc(lt_reg[LT_ICMP],  hit.icmp);
        lt_next[LT_OTHER] = sat_inc(lt_reg[LT_OTHER], hit.other);

        // Window counts are tested before they are cleared at the window end.
        alarm[WN_SYN]  = clear_window && (win_reg[WN_SYN]  > thr_reg[WN_SYN]);
        alarm[WN_ACK]  = clear_window && (win_reg[WN_ACK]  > thr_reg[WN_ACK]);
        alarm[WN_UDP]  = clear_window && (win_reg[WN_UDP]  > thr_reg[WN_UDP]);
        alarm[WN_ICMP] = clear_window && (win_reg[WN_ICMP] > thr_reg[WN_ICMP]);

        if (clear_window) begin
            for (int i = 0; i < NUM_WN; i++) begin
                win_next[i] = '0;
            end
        end else begin
            win_next[WN_SYN]  = sat_inc(win_reg[WN_SYN],  hit.syn);
            win_next[WN_ACK]  = sat_inc(win_reg[WN_ACK],  hit.ack);
            win_next[WN_UDP]  = sat_inc(win_reg[WN_UDP],  hit.udp);
            win_next[WN_ICMP] = sat_inc(win_reg[WN_ICMP], hit.icmp);
        end

        // The rate is loaded directly from zero, otherwise it is the floor of
        // the mean of the old rate and this second's count.
        rate_sum = {1'b0, rate_reg} + {1'b0, spc_reg};
        if (!is_tick) begin
            rate_next = rate_reg;
        end else if (rate_reg == '0) begin
            rate_next = spc_reg;
        end else begin
            rate_next = rate_sum[CNT_W:1];
        end

        spc_next = is_tick ? '0 : sat_inc(spc_reg, hit.counted);

        if (!is_tick) begin
            tick_next = tick_reg;
        end else if (window_end) begin
            tick_next = '0;
        end else begin
            tick_next = tick_reg + 1'b1;
        end

        out_data_next = {alarm, rate_next,
                         lt_next[LT_OTHER], lt_next[LT_ICMP], lt_next[LT_UDP],
                         lt_next[LT_ACK], lt_next[LT_SYN], lt_next[LT_TOTAL],
                         hit.cls};
    end

    // Input stage. Payload needs no reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_op_reg    <= s_tuser[0];
            in_etype_reg <= s_tdata[15:0];
            in_proto_reg <= s_tdata[23:16];
            in_flags_reg <= s_tdata[31:24];
        end
    end

    // Result stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= in_valid_reg;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    // Counting state commits when a request moves into the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_LT; i++) begin
                lt_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_WN; i++) begin
                win_reg[i] <= '0;
            end
            spc_reg  <= '0;
            rate_reg <= '0;
            tick_reg <= '0;
        end else if (advance) begin
            for (int i = 0; i < NUM_LT; i++) begin
                lt_reg[i] <= lt_next[i];
            end
            for (int i = 0; i < NUM_WN; i++) begin
                win_reg[i] <= win_next[i];
            end
            spc_reg  <= spc_next;
            rate_reg <= rate_next;
            tick_reg <= tick_next;
        end
    end

    // Configuration writes; indexes past the register list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_WN; i++) begin
                thr_reg[i] <= THR_RESET;
            end
            mode_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_SYN_THR:  thr_reg[WN_SYN]  <= cfg_data;
                CFG_ACK_THR:  thr_reg[WN_ACK]  <= cfg_data;
                CFG_UDP_THR:  thr_reg[WN_UDP]  <= cfg_data;
                CFG_ICMP_THR: thr_reg[WN_ICMP] <= cfg_data;
                CFG_MODE:     mode_reg         <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== sv/pcfd_checker.sv =====
module pcfd_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [pcfd_pkg::M_DATA_W-1:0]  m_tdata
);
    import pcfd_pkg::*;

    // The result channel is empty in the cycle after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A stalled result holds its contents.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Packet results never carry alarms; only ticks do.
    a_packet_no_alarm: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[3:0] != CLS_NONE) |-> (m_tdata[231:228] == 4'b0000))
        else $error("alarm on a packet result");

    // The class code stays within the defined classes.
    a_class_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3:0] <= CLS_OTHER))
        else $error("undefined packet class");

endmodule

bind packet_class_flood_detector_core pcfd_checker u_pcfd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
